/* hdl/cste_pkg.sv */
// cste_pkg: types, codes and the command frame builder of the servo transaction engine
// used by cste_ctrl, cste_dp, cste_checker and can_servo_transaction_engine_core
`default_nettype none
package cste_pkg;

    localparam int unsigned DIV_STEPS = 32;

    // item kinds
    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_FRAME   = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    // operations
    localparam logic [3:0] OP_MODE     = 4'd0;
    localparam logic [3:0] OP_ENABLE   = 4'd1;
    localparam logic [3:0] OP_DISABLE  = 4'd2;
    localparam logic [3:0] OP_MOVE     = 4'd3;
    localparam logic [3:0] OP_STOP     = 4'd4;
    localparam logic [3:0] OP_ACCEL    = 4'd5;
    localparam logic [3:0] OP_DECEL    = 4'd6;
    localparam logic [3:0] OP_VEL      = 4'd7;
    localparam logic [3:0] OP_RELPOS   = 4'd8;
    localparam logic [3:0] OP_ABSPOS   = 4'd9;
    localparam logic [3:0] OP_ANALOG   = 4'd10;
    localparam logic [3:0] OP_RD_POS   = 4'd11;
    localparam logic [3:0] OP_RD_VEL   = 4'd12;
    localparam logic [3:0] OP_RD_TRQ   = 4'd13;
    localparam logic [3:0] OP_RD_STATE = 4'd14;

    // servo modes
    localparam logic [2:0] MODE_CONT_POS = 3'd2;
    localparam logic [2:0] MODE_VEL      = 3'd3;
    localparam logic [2:0] MODE_FORCE    = 3'd4;

    // reply kinds
    localparam logic [2:0] RK_WRITE = 3'd0;
    localparam logic [2:0] RK_STATE = 3'd1;
    localparam logic [2:0] RK_POS   = 3'd2;
    localparam logic [2:0] RK_VEL   = 3'd3;
    localparam logic [2:0] RK_TRQ   = 3'd4;

    // result kinds
    localparam logic RES_FRAME  = 1'b0;
    localparam logic RES_FINISH = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_ID = 2'd0;
    localparam logic [1:0] CFG_CPT     = 2'd1;
    localparam logic [1:0] CFG_LOCKED  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [10:0] CMD_ID_BASE   = 11'h640;
    localparam logic [10:0] REPLY_ID_BASE = 11'h5C0;
    localparam logic [7:0]  ACK_BYTE      = 8'h3E;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_ctl_sts;

    typedef struct packed {
        logic [2:0]  len;
        logic [47:0] bytes;
    } t_frame;

    function automatic t_frame fn_frame(input logic [3:0] op, input logic [2:0] mode,
                                        input logic [1:0] step, input logic [31:0] arg);
        t_frame f;
        logic [7:0] b0, b1, b2, b3, b4, b5;
        b0 = 8'h00; b1 = 8'h00; b2 = 8'h00; b3 = 8'h00; b4 = 8'h00; b5 = 8'h00;
        f.len = 3'd6;
        case (op)
            OP_MODE: begin
                if (step == 2'd0) begin
                    b1 = 8'h4E;
                    b5 = (mode <= MODE_CONT_POS) ? 8'h03 : ((mode == MODE_VEL) ? 8'h02 : 8'h01);
                end else if (mode <= MODE_CONT_POS) begin
                    b1 = 8'h8D;
                    b5 = (mode == MODE_CONT_POS) ? 8'h00 : 8'h01;
                end else begin
                    b0 = 8'h01;
                    b1 = (step == 2'd1) ? 8'h12 : 8'hFD;
                end
            end
            OP_ENABLE:   begin b0 = 8'h01; b5 = 8'h01; end
            OP_DISABLE:  begin b0 = 8'h01; end
            OP_MOVE:     begin b1 = 8'h83; f.len = 3'd2; end
            OP_STOP:     begin b1 = 8'h84; f.len = 3'd2; end
            OP_RD_POS:   begin b1 = 8'h02; f.len = 3'd2; end
            OP_RD_VEL:   begin b1 = 8'h05; b3 = 8'h01; f.len = 3'd4; end
            OP_RD_TRQ:   begin b0 = 8'h02; b1 = 8'h0D; f.len = 3'd2; end
            OP_RD_STATE: begin b1 = 8'h20; f.len = 3'd2; end
            default: begin
                b0 = (op == OP_ANALOG) ? 8'h01 : 8'h00;
                case (op)
                    OP_ACCEL:  b1 = 8'h88;
                    OP_DECEL:  b1 = 8'h89;
                    OP_VEL:    b1 = 8'h8A;
                    OP_RELPOS: b1 = 8'h87;
                    OP_ABSPOS: b1 = 8'h86;
                    default:   b1 = 8'hFE;
                endcase
                b2 = arg[31:24];
                b3 = arg[23:16];
                b4 = arg[15:8];
                b5 = arg[7:0];
            end
        endcase
        f.bytes = {b0, b1, b2, b3, b4, b5};
        return f;
    endfunction

endpackage
`default_nettype wire

/* hdl/cste_ctrl.sv */
// cste_ctrl: sequencer of the servo transaction engine
// steps the remainder unit of cste_dp; uses cste_pkg
`default_nettype none
module cste_ctrl
    import cste_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.need_div) begin
                        n_state = ST_DIV;
                        n_cnt   = 5'd0;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule
`default_nettype wire

/* hdl/cste_dp.sv */
// cste_dp: registers, frame building, reply checks and offset remainder unit
// driven by cste_ctrl; uses cste_pkg
`default_nettype none
module cste_dp
    import cste_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [24:0] i_cfg_data,
    input  wire t_ctl_cmd    i_cmd,
    output t_ctl_sts         o_sts,
    input  wire logic [1:0]  i_command,
    input  wire logic [3:0]  i_operation,
    input  wire logic [2:0]  i_op_mode,
    input  wire logic signed [31:0] i_argument,
    input  wire logic [10:0] i_rx_id,
    input  wire logic [3:0]  i_rx_len,
    input  wire logic [39:0] i_rx_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_result_kind,
    output logic [10:0]      o_frame_id,
    output logic [2:0]       o_frame_len,
    output logic [47:0]      o_frame_bytes,
    output logic [2:0]       o_reply_kind,
    output logic signed [31:0] o_reading
);
    logic [6:0]  r_node_id;
    logic [24:0] r_cpt;
    logic        r_locked;
    logic [7:0]  r_timeout;

    logic        r_busy, n_busy;
    logic [3:0]  r_pop, n_pop;
    logic [2:0]  r_pmode, n_pmode;
    logic [31:0] r_parg, n_parg;
    logic [1:0]  r_step, n_step;
    logic [2:0]  r_exp, n_exp;
    logic [2:0]  r_cur_mode, n_cur_mode;
    logic [31:0] r_offset, n_offset;
    logic [7:0]  r_wait, n_wait;

    logic        r_out_valid;
    logic        r_kind;
    logic [10:0] r_fid;
    logic [2:0]  r_flen;
    logic [47:0] r_fbytes;
    logic [2:0]  r_rkind;
    logic [31:0] r_reading;

    // remainder unit
    logic [31:0] r_value;
    logic [31:0] r_dvd;
    logic [24:0] r_rem;
    logic        r_neg;

    logic        emit, finish_now, need_div;
    t_frame      frm;
    logic [31:0] fin_reading;
    logic [7:0]  timer_load;
    logic [31:0] value, req_arg;
    logic [3:0]  f_op;
    logic [2:0]  f_mode;
    logic [1:0]  f_step;
    logic [31:0] f_arg;
    logic        id_hit, good, req_ok;
    logic [2:0]  fcount;
    logic [25:0] rem_sh;
    logic signed [33:0] rs, cpt_s, pos_s;
    logic [31:0] div_offset;

    assign value      = i_rx_data[39:8];
    assign timer_load = (r_timeout == 8'd0) ? 8'd1 : r_timeout;
    assign fcount     = (r_pop == OP_MODE) ? ((r_pmode <= MODE_CONT_POS) ? 3'd2 : 3'd3) : 3'd1;
    assign id_hit     = r_busy && (i_rx_id == (REPLY_ID_BASE + {4'd0, r_node_id}));
    assign good       = (r_exp == RK_WRITE) ? ((i_rx_len == 4'd1) && (i_rx_data[39:32] == ACK_BYTE))
                                            : ((i_rx_len == 4'd5) && (i_rx_data[7:0] == ACK_BYTE));
    assign req_ok     = !r_busy && (i_operation != 4'd15)
                        && !((i_operation == OP_MODE) && (i_op_mode > MODE_FORCE));

    always_comb begin
        if (i_operation == OP_ABSPOS) begin
            req_arg = i_argument + r_offset;
        end else if ((i_operation == OP_ANALOG) && (r_cur_mode != MODE_VEL)
                     && (r_cur_mode != MODE_FORCE)) begin
            req_arg = 32'd0;
        end else begin
            req_arg = i_argument;
        end
    end

    always_comb begin
        n_busy = r_busy; n_pop = r_pop; n_pmode = r_pmode; n_parg = r_parg;
        n_step = r_step; n_exp = r_exp; n_cur_mode = r_cur_mode;
        n_offset = r_offset; n_wait = r_wait;
        emit = 1'b0; finish_now = 1'b0; need_div = 1'b0;
        fin_reading = 32'd0;
        f_op = r_pop; f_mode = r_pmode; f_step = r_step; f_arg = r_parg;
        case (i_command)
            CMD_REQUEST: begin
                if (req_ok) begin
                    emit = 1'b1;
                    n_pop = i_operation; n_pmode = i_op_mode; n_parg = req_arg;
                    n_step = 2'd0; n_busy = 1'b1;
                    f_op = i_operation; f_mode = i_op_mode; f_step = 2'd0; f_arg = req_arg;
                    case (i_operation)
                        OP_RD_POS:   n_exp = RK_POS;
                        OP_RD_VEL:   n_exp = RK_VEL;
                        OP_RD_TRQ:   n_exp = RK_TRQ;
                        OP_RD_STATE: n_exp = RK_STATE;
                        default:     n_exp = RK_WRITE;
                    endcase
                end
            end
            CMD_FRAME: begin
                if (id_hit) begin
                    if (!good) begin
                        emit = 1'b1;
                    end else if ((r_exp == RK_WRITE) && ({1'b0, r_step} + 3'd1 < fcount)) begin
                        emit = 1'b1;
                        n_step = r_step + 2'd1;
                        f_step = r_step + 2'd1;
                    end else if ((r_exp == RK_POS) && !r_locked && (r_cpt != 25'd0)) begin
                        need_div = 1'b1;
                    end else begin
                        finish_now = 1'b1;
                        n_busy = 1'b0;
                        n_wait = 8'd0;
                        if (r_pop == OP_MODE) begin
                            n_cur_mode = r_pmode;
                        end
                        if (r_exp == RK_POS) begin
                            if (!r_locked) begin
                                n_offset = 32'd0;
                                fin_reading = value;
                            end else begin
                                fin_reading = value - r_offset;
                            end
                        end else if (r_exp != RK_WRITE) begin
                            fin_reading = value;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (r_busy) begin
                    if (r_wait <= 8'd1) begin
                        emit = 1'b1;
                    end else begin
                        n_wait = r_wait - 8'd1;
                    end
                end
            end
            default: ;
        endcase
        if (emit) begin
            n_wait = timer_load;
        end
    end

    assign frm = fn_frame(f_op, f_mode, f_step, f_arg);

    // rounding of the remainder to the nearest turn
    always_comb begin
        cpt_s = {9'd0, r_cpt};
        pos_s = {{2{r_value[31]}}, r_value};
        rs    = r_neg ? -$signed({9'd0, r_rem}) : $signed({9'd0, r_rem});
        if ((rs <<< 1) > cpt_s) begin
            rs = rs - cpt_s;
        end
        if ((rs <<< 1) < -cpt_s) begin
            rs = rs + cpt_s;
        end
        div_offset = 32'(pos_s - rs);
    end

    assign rem_sh = {r_rem, r_dvd[31]};

    assign o_sts.need_div = need_div;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= 7'd1;
            r_cpt     <= 25'd524288;
            r_locked  <= 1'b0;
            r_timeout <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_ID: r_node_id <= i_cfg_data[6:0];
                CFG_CPT:     r_cpt     <= i_cfg_data;
                CFG_LOCKED:  r_locked  <= i_cfg_data[0];
                CFG_TIMEOUT: r_timeout <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_pop <= 4'd0; r_pmode <= 3'd0; r_parg <= 32'd0;
            r_step <= 2'd0; r_exp <= RK_WRITE; r_cur_mode <= 3'd0;
            r_offset <= 32'd0; r_wait <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_busy <= n_busy; r_pop <= n_pop; r_pmode <= n_pmode; r_parg <= n_parg;
                r_step <= n_step; r_exp <= n_exp; r_cur_mode <= n_cur_mode;
                r_offset <= n_offset; r_wait <= n_wait;
            end else if (i_cmd.finish) begin
                r_busy <= 1'b0;
                r_wait <= 8'd0;
                r_offset <= div_offset;
                if (r_pop == OP_MODE) begin
                    r_cur_mode <= r_pmode;
                end
            end
            if ((i_cmd.accept && (emit || finish_now)) || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_value <= value;
            r_neg   <= value[31];
            r_dvd   <= value[31] ? (32'd0 - value) : value;
            r_rem   <= 25'd0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            if (rem_sh >= {1'b0, r_cpt}) begin
                r_rem <= 25'(rem_sh - {1'b0, r_cpt});
            end else begin
                r_rem <= rem_sh[24:0];
            end
        end
        if (i_cmd.accept && emit) begin
            r_kind    <= RES_FRAME;
            r_fid     <= CMD_ID_BASE + {4'd0, r_node_id};
            r_flen    <= frm.len;
            r_fbytes  <= frm.bytes;
            r_rkind   <= RK_WRITE;
            r_reading <= 32'd0;
        end else if (i_cmd.accept && finish_now) begin
            r_kind    <= RES_FINISH;
            r_fid     <= 11'd0;
            r_flen    <= 3'd0;
            r_fbytes  <= 48'd0;
            r_rkind   <= r_exp;
            r_reading <= fin_reading;
        end else if (i_cmd.finish) begin
            r_kind    <= RES_FINISH;
            r_fid     <= 11'd0;
            r_flen    <= 3'd0;
            r_fbytes  <= 48'd0;
            r_rkind   <= RK_POS;
            r_reading <= r_value - div_offset;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_frame_id    = r_fid;
    assign o_frame_len   = r_flen;
    assign o_frame_bytes = r_fbytes;
    assign o_reply_kind  = r_rkind;
    assign o_reading     = r_reading;
endmodule
`default_nettype wire

/* hdl/can_servo_transaction_engine_core.sv */
// can_servo_transaction_engine_core: top level of the servo transaction engine
// joins cste_ctrl and cste_dp; uses cste_pkg
`default_nettype none
// Host-side engine that turns requests into CAN command frames (id 0x640 + node),
// checks replies (id 0x5C0 + node), resends on a bad reply or on timeout ticks and
// reports each finished transaction with its reading. Each item is done in the
// cycle it is taken, except a good position reply with the zero offset unlocked:
// that one holds the input off while the 32-step remainder unit wraps the offset
// to a whole turn. Results sit in an output register; while a result waits the
// input is held off, and the next item is taken in the cycle the result leaves.
module can_servo_transaction_engine_core
    import cste_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [24:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [3:0]  i_operation,
    input  wire logic [2:0]  i_op_mode,
    input  wire logic signed [31:0] i_argument,
    input  wire logic [10:0] i_rx_id,
    input  wire logic [3:0]  i_rx_len,
    input  wire logic [39:0] i_rx_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_result_kind,
    output logic [10:0]      o_frame_id,
    output logic [2:0]       o_frame_len,
    output logic [47:0]      o_frame_bytes,
    output logic [2:0]       o_reply_kind,
    output logic signed [31:0] o_reading
);
    t_ctl_cmd cmd;
    t_ctl_sts sts;

    cste_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cste_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_command     (i_command),
        .i_operation   (i_operation),
        .i_op_mode     (i_op_mode),
        .i_argument    (i_argument),
        .i_rx_id       (i_rx_id),
        .i_rx_len      (i_rx_len),
        .i_rx_data     (i_rx_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_frame_id    (o_frame_id),
        .o_frame_len   (o_frame_len),
        .o_frame_bytes (o_frame_bytes),
        .o_reply_kind  (o_reply_kind),
        .o_reading     (o_reading)
    );
endmodule
`default_nettype wire

/* hdl/cste_checker.sv */
// cste_checker: port-level assertions for the servo transaction engine
// bound to can_servo_transaction_engine_core; uses cste_pkg
`default_nettype none
module cste_checker
    import cste_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_result_kind,
    input wire logic [2:0]  o_frame_len,
    input wire logic [47:0] o_frame_bytes,
    input wire logic [31:0] o_reading
);
    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_bytes)
        && $stable(o_reading))
        else $error("result changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == RES_FRAME) |->
        (o_frame_len == 3'd2) || (o_frame_len == 3'd4) || (o_frame_len == 3'd6))
        else $error("bad frame length");

    a_finish_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == RES_FINISH) |->
        (o_frame_len == 3'd0) && (o_frame_bytes == 48'd0))
        else $error("finished result carries frame data");
endmodule

bind can_servo_transaction_engine_core cste_checker u_cste_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_kind (o_result_kind),
    .o_frame_len   (o_frame_len),
    .o_frame_bytes (o_frame_bytes),
    .o_reading     (o_reading)
);
`default_nettype wire
